// File: rtl/cfr_pkg.sv
package cfr_pkg;

  // Frame layout: five data bytes followed by one CRC byte.
  localparam int unsigned FRAME_DATA = 5;
  localparam int unsigned POS_W      = 3;

  // Reflected form of the polynomial 0x31 (Dallas/Maxim CRC-8).
  localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

  // Saturation limits.
  localparam logic [POS_W-1:0] COUNT_MAX   = 3'd7;
  localparam logic [7:0]       SILENCE_MAX = 8'hFF;
  localparam logic [7:0]       REPEAT_MAX  = 8'hFF;

  // Reset values of the configuration registers.
  localparam logic [7:0] CRC_SEED_RST     = 8'h5A;
  localparam logic [7:0] LINK_TIMEOUT_RST = 8'd5;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_SEED     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_TIMEOUT = 1'b1;

  // Item kinds carried on the input tuser.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Width of the packed result word.
  localparam int unsigned OUT_DATA_W = 48;

  typedef logic [FRAME_DATA-1:0][7:0] frame_t;

  // One result word before packing.
  typedef struct packed {
    logic        frame_checked;
    logic        frame_good;
    logic        fields_updated;
    logic [7:0]  horiz_state;
    logic [7:0]  vert_state;
    logic [7:0]  power_state;
    logic [15:0] battery_voltage;
    logic        link_lost;
  } result_t;

endpackage

// File: rtl/cfr_crc8.sv
module cfr_crc8
  import cfr_pkg::*;
(
  input  logic [7:0] crc_in,
  input  logic [7:0] data_in,
  output logic [7:0] crc_out
);

  // Bytewise reflected CRC-8: eight shift steps on an 8-bit value.
  always_comb begin
    logic [7:0] c;
    c = crc_in ^ data_in;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

// File: rtl/crc8_confirmed_frame_receiver.sv
// Receives link bytes (tuser low) and one-second ticks (tuser high) and returns
// exactly one result word for every input word, one word per clock cycle
// while out_tready is high: the word is captured in an input register, the
// CRC-8 byte step and the frame checks run in a single cycle, and the result
// lands in an output register backed by a one-word skid register, so input is
// still taken while a result waits. A frame is five data bytes and a CRC-8
// byte (reflected 0x31, seed from register 0) closed by tlast; frames of any
// other length are dropped. A good frame clears the silence counter; the first
// good frame that matches the previous good frame latches the state, power and
// battery fields. link_lost is high while the tick count since the last good
// frame is at least the timeout in register 1.
module crc8_confirmed_frame_receiver
  import cfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]            cfg_wdata,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] rx_byte
  input  logic                  in_tuser,   // [0] operation
  input  logic                  in_tlast,   // last_byte
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] frame_checked, [1] frame_good, [2] fields_updated, [10:3] horiz_state,
  // [18:11] vert_state, [26:19] power_state, [42:27] battery_voltage,
  // [43] link_lost, [47:44] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // Configuration registers.
  logic [7:0] crc_seed_r;
  logic [7:0] link_timeout_r;

  // Input register.
  logic       item_valid_r;
  logic       item_op_r;
  logic [7:0] item_byte_r;
  logic       item_last_r;

  // Receiver state.
  logic [POS_W-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]       running_crc_r, running_crc_nxt;
  frame_t           frame_store_r, frame_store_nxt;
  frame_t           previous_frame_r, previous_frame_nxt;
  logic [7:0]       repeat_count_r, repeat_count_nxt;
  logic [7:0]       silence_count_r, silence_count_nxt;
  logic [7:0]       horiz_r, horiz_nxt;
  logic [7:0]       vert_r, vert_nxt;
  logic [7:0]       power_r, power_nxt;
  logic [15:0]      battery_r, battery_nxt;

  // Output register and skid register.
  logic    out_valid_r;
  result_t out_res_r;
  logic    skid_valid_r;
  result_t skid_res_r;

  logic       advance;
  logic       pop;
  logic [7:0] crc_base;
  logic [7:0] crc_step;
  result_t    res_nxt;

  // A word leaves the input register whenever the skid register is free.
  assign advance   = item_valid_r && !skid_valid_r;
  assign pop       = out_valid_r && out_tready;
  assign in_tready = !item_valid_r || advance;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_seed_r     <= CRC_SEED_RST;
      link_timeout_r <= LINK_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CRC_SEED:     crc_seed_r     <= cfg_wdata;
        REG_LINK_TIMEOUT: link_timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_op_r   <= in_tuser;
      item_byte_r <= in_tdata;
      item_last_r <= in_tlast;
    end
  end

  // The first byte of a frame starts from the seed.
  assign crc_base = (byte_count_r == '0) ? crc_seed_r : running_crc_r;

  cfr_crc8 u_crc8 (
    .crc_in  (crc_base),
    .data_in (item_byte_r),
    .crc_out (crc_step)
  );

  // Next state and result for the word in the input register.
  always_comb begin
    logic [7:0] rep_inc;
    byte_count_nxt     = byte_count_r;
    running_crc_nxt    = running_crc_r;
    frame_store_nxt    = frame_store_r;
    previous_frame_nxt = previous_frame_r;
    repeat_count_nxt   = repeat_count_r;
    silence_count_nxt  = silence_count_r;
    horiz_nxt          = horiz_r;
    vert_nxt           = vert_r;
    power_nxt          = power_r;
    battery_nxt        = battery_r;
    res_nxt            = '0;
    rep_inc = (repeat_count_r != REPEAT_MAX) ? repeat_count_r + 8'd1 : repeat_count_r;

    if (item_op_r == OP_TICK) begin
      if (silence_count_r != SILENCE_MAX) begin
        silence_count_nxt = silence_count_r + 8'd1;
      end
    end else begin
      // Data bytes are stored and folded into the CRC.
      if (byte_count_r < POS_W'(FRAME_DATA)) begin
        frame_store_nxt[byte_count_r] = item_byte_r;
        running_crc_nxt               = crc_step;
      end
      if (item_last_r) begin
        // Only a six-byte frame is checked; the CRC byte is at position five.
        if (byte_count_r == POS_W'(FRAME_DATA)) begin
          res_nxt.frame_checked = 1'b1;
          if (item_byte_r == running_crc_r) begin
            res_nxt.frame_good = 1'b1;
            silence_count_nxt  = '0;
            if (previous_frame_r == frame_store_r) begin
              repeat_count_nxt = rep_inc;
              if (rep_inc == 8'd1) begin
                horiz_nxt   = frame_store_r[0];
                vert_nxt    = frame_store_r[1];
                power_nxt   = frame_store_r[2];
                battery_nxt = {frame_store_r[4], frame_store_r[3]};
                res_nxt.fields_updated = 1'b1;
              end
            end else begin
              previous_frame_nxt = frame_store_r;
              repeat_count_nxt   = '0;
            end
          end
        end
        byte_count_nxt  = '0;
        running_crc_nxt = crc_seed_r;
      end else if (byte_count_r < COUNT_MAX) begin
        byte_count_nxt = byte_count_r + 1'b1;
      end
    end

    res_nxt.horiz_state     = horiz_nxt;
    res_nxt.vert_state      = vert_nxt;
    res_nxt.power_state     = power_nxt;
    res_nxt.battery_voltage = battery_nxt;
    res_nxt.link_lost       = (silence_count_nxt >= link_timeout_r);
  end

  // Receiver state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r     <= '0;
      running_crc_r    <= CRC_SEED_RST;
      previous_frame_r <= '0;
      repeat_count_r   <= '0;
      silence_count_r  <= '0;
      horiz_r          <= '0;
      vert_r           <= '0;
      power_r          <= '0;
      battery_r        <= '0;
    end else if (advance) begin
      byte_count_r     <= byte_count_nxt;
      running_crc_r    <= running_crc_nxt;
      previous_frame_r <= previous_frame_nxt;
      repeat_count_r   <= repeat_count_nxt;
      silence_count_r  <= silence_count_nxt;
      horiz_r          <= horiz_nxt;
      vert_r           <= vert_nxt;
      power_r          <= power_nxt;
      battery_r        <= battery_nxt;
    end
  end

  // The frame store is always written before it is read.
  always_ff @(posedge clk) begin
    if (advance) begin
      frame_store_r <= frame_store_nxt;
    end
  end

  // Output register with skid: a new result goes to the output register when
  // it is free or being emptied, otherwise it waits in the skid register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (advance) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_res_r <= skid_res_r;
      end
    end else if (advance) begin
      if (!out_valid_r || pop) begin
        out_res_r <= res_nxt;
      end else begin
        skid_res_r <= res_nxt;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000,
                       out_res_r.link_lost,
                       out_res_r.battery_voltage,
                       out_res_r.power_state,
                       out_res_r.vert_state,
                       out_res_r.horiz_state,
                       out_res_r.fields_updated,
                       out_res_r.frame_good,
                       out_res_r.frame_checked};

  // A waiting skid word always has a word ahead of it.
  assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a word while the output register is empty");

  // A tick leaves the frame in progress untouched.
  assert property (@(posedge clk) disable iff (!rst_n)
    (advance && item_op_r == OP_TICK) |=> ($stable(byte_count_r) && $stable(running_crc_r)))
    else $error("tick disturbed the frame in progress");

  // A good frame clears the silence counter.
  assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_nxt.frame_good) |=> (silence_count_r == '0))
    else $error("silence counter not cleared by a good frame");

  // Fields are latched only on a good frame whose repeat count became one.
  assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_nxt.fields_updated) |=> (repeat_count_r == 8'd1))
    else $error("fields latched with repeat count other than one");

endmodule
